// File: sv/ltd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared types and constants of the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package ltd_pkg;

	localparam int MaxFracDigits = 12;
	localparam int IntSlots      = 10;
	localparam int DigSlots      = IntSlots + MaxFracDigits;
	localparam int MsecShift     = 3;

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharMinus = 8'h2d;
	localparam logic [7:0] CharPoint = 8'h2e;

	typedef logic [3:0] digit_t;
	typedef logic [4:0] slot_t;

	// One classified transaction as handed from the front to the back.
	typedef struct packed {
		logic        neg;
		logic [31:0] whole;
		logic [31:0] frac;
		logic [3:0]  dec;
		logic        msec;
	} item_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_INT,
		B_FRAC,
		B_ROUND,
		B_SCAN,
		B_SIGN,
		B_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// File: sv/long_fixed_to_decimal_text.sv
`default_nettype none
// ----------------------------------------------------------------------------
// long_fixed_to_decimal_text
// Converts a signed 32.32 fixed-point value into decimal ASCII characters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | whole_part, fraction_part,
//          |           |                      | decimals, millisecond_mode
//  out     | output    | out_valid / out_stall| character, last_char
//
// A value passes ten integer digits (one divide-by-ten per cycle), then
// the fraction digits, a rounding carry when needed, a leading-zero scan
// and the characters, one per cycle while out_stall is low.
// The digit sequencer handles one value at a time; a two-entry queue lets
// new values be accepted meanwhile. Reset is asynchronous and needs no
// clearing pass. The output register holds its character while out_stall.
// ----------------------------------------------------------------------------
module long_fixed_to_decimal_text (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] whole_part,
	input  wire logic [31:0] fraction_part,
	input  wire logic [3:0]  decimals,
	input  wire logic        millisecond_mode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       character,
	output logic             last_char
);
	import ltd_pkg::*;

	item_t cls_item;
	item_t head_item;
	logic  full, push, pop, head_valid;

	assign in_stall = full;
	assign push     = in_valid && !full;

	ltd_front u_front (
		.whole_part       (whole_part),
		.fraction_part    (fraction_part),
		.decimals         (decimals),
		.millisecond_mode (millisecond_mode),
		.item             (cls_item)
	);

	ltd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (cls_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ltd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character),
		.last_char  (last_char)
	);

endmodule
`default_nettype wire

// File: sv/ltd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_front
// Classifies an input value: sign, magnitude and the effective digit count.
// ----------------------------------------------------------------------------
module ltd_front (
	input  wire logic [31:0]  whole_part,
	input  wire logic [31:0]  fraction_part,
	input  wire logic [3:0]   decimals,
	input  wire logic         millisecond_mode,
	output ltd_pkg::item_t    item
);
	import ltd_pkg::*;

	logic        neg;
	logic [63:0] raw;
	logic [63:0] mag;
	logic [4:0]  dsum;
	logic [3:0]  dcnt;

	assign neg  = whole_part[31];
	assign raw  = {whole_part, fraction_part};
	assign mag  = neg ? (64'd0 - raw) : raw;
	assign dsum = {1'b0, decimals} + (millisecond_mode ? 5'(MsecShift) : 5'd0);

	always_comb begin
		if (dsum > 5'(MaxFracDigits))
			dcnt = 4'(MaxFracDigits);
		else
			dcnt = dsum[3:0];
		// Millisecond text needs at least the three digits that move before the point.
		if (millisecond_mode && dcnt < 4'(MsecShift))
			dcnt = 4'(MsecShift);
	end

	assign item.neg   = neg;
	assign item.whole = mag[63:32];
	assign item.frac  = mag[31:0];
	assign item.dec   = dcnt;
	assign item.msec  = millisecond_mode;

endmodule
`default_nettype wire

// File: sv/ltd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_queue
// Two-entry queue that decouples the classifier from the text sequencer.
// ----------------------------------------------------------------------------
module ltd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  ltd_pkg::item_t       push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output ltd_pkg::item_t       head_item
);
	import ltd_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// File: sv/ltd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_back
// Digit sequencer: integer digits, fraction digits, rounding, zero strip and
// character output through a registered output stage.
// ----------------------------------------------------------------------------
module ltd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  ltd_pkg::item_t     head_item,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         character,
	output logic               last_char
);
	import ltd_pkg::*;

	back_state_t state_q, state_d;

	digit_t      dig_q [DigSlots];
	logic        neg_q, msec_q, dot_q, dot_d;
	logic [31:0] x_q, x_d;
	logic [31:0] f_q, f_d;
	slot_t       end_q, end_d;
	slot_t       idx_q, idx_d;
	logic        neg_d, msec_d;

	logic        dig_we;
	slot_t       dig_wa;
	digit_t      dig_wd;
	digit_t      rd;

	logic [63:0] prod;
	logic [31:0] quot;
	logic [31:0] rem;
	logic [35:0] fprod;
	digit_t      inc;
	slot_t       point;

	logic        ov_q, free, load;
	logic [7:0]  ch_d;
	logic        last_d;

	assign rd    = (idx_q < 5'(DigSlots)) ? dig_q[idx_q] : 4'd0;
	// Divide by ten through the reciprocal; exact for every 32-bit value.
	assign prod  = {32'd0, x_q} * 64'h0000_0000_CCCC_CCCD;
	assign quot  = {3'd0, prod[63:35]};
	assign rem   = x_q - ((quot << 3) + (quot << 1));
	assign fprod = ({4'd0, f_q} << 3) + ({4'd0, f_q} << 1);
	assign inc   = rd + 4'd1;
	assign point = msec_q ? 5'(IntSlots + MsecShift) : 5'(IntSlots);
	assign free  = !ov_q || !out_stall;

	always_comb begin
		state_d = state_q;
		x_d     = x_q;
		f_d     = f_q;
		end_d   = end_q;
		idx_d   = idx_q;
		neg_d   = neg_q;
		msec_d  = msec_q;
		dot_d   = dot_q;
		dig_we  = 1'b0;
		dig_wa  = idx_q;
		dig_wd  = 4'd0;
		pop     = 1'b0;
		load    = 1'b0;
		ch_d    = CharZero;
		last_d  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					neg_d   = head_item.neg;
					msec_d  = head_item.msec;
					x_d     = head_item.whole;
					f_d     = head_item.frac;
					end_d   = 5'(IntSlots) + {1'b0, head_item.dec};
					idx_d   = 5'(IntSlots - 1);
					state_d = B_INT;
				end
			end
			B_INT: begin
				dig_we = 1'b1;
				dig_wd = rem[3:0];
				x_d    = quot;
				if (idx_q == 5'd0) begin
					idx_d   = 5'(IntSlots);
					state_d = B_FRAC;
				end else begin
					idx_d = idx_q - 5'd1;
				end
			end
			B_FRAC: begin
				if (idx_q == end_q) begin
					if (f_q[31]) begin
						idx_d   = end_q - 5'd1;
						state_d = B_ROUND;
					end else begin
						idx_d   = 5'd0;
						state_d = B_SCAN;
					end
				end else begin
					dig_we = 1'b1;
					dig_wd = fprod[35:32];
					f_d    = fprod[31:0];
					idx_d  = idx_q + 5'd1;
				end
			end
			B_ROUND: begin
				dig_we = 1'b1;
				if (inc == 4'd10 && idx_q != 5'd0) begin
					dig_wd = 4'd0;
					idx_d  = idx_q - 5'd1;
				end else begin
					dig_wd  = inc;
					idx_d   = 5'd0;
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				// One digit always stays in front of the point.
				if (rd == 4'd0 && idx_q != point - 5'd1) begin
					idx_d = idx_q + 5'd1;
				end else begin
					dot_d   = 1'b0;
					state_d = neg_q ? B_SIGN : B_EMIT;
				end
			end
			B_SIGN: begin
				if (free) begin
					load    = 1'b1;
					ch_d    = CharMinus;
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (free) begin
					load = 1'b1;
					if (idx_q == point && !dot_q) begin
						ch_d  = CharPoint;
						dot_d = 1'b1;
					end else begin
						ch_d   = CharZero + {4'd0, rd};
						last_d = (idx_q + 5'd1 == end_q);
						idx_d  = idx_q + 5'd1;
						if (last_d)
							state_d = B_IDLE;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dig_we)
			dig_q[dig_wa] <= dig_wd;
		x_q    <= x_d;
		f_q    <= f_d;
		end_q  <= end_d;
		idx_q  <= idx_d;
		neg_q  <= neg_d;
		msec_q <= msec_d;
		dot_q  <= dot_d;
		if (load) begin
			character <= ch_d;
			last_char <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

`ifndef SYNTHESIS
	a_int_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_INT) |-> (idx_q < 5'(IntSlots)))
		else $error("integer digit slot out of range");
	a_round_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ROUND && idx_q == 5'd0) |-> (rd != 4'd9))
		else $error("rounding carried out of the top digit");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (idx_q < end_q))
		else $error("emit pointer passed the last digit");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |-> !load)
		else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire
